// ===== rtl/arc_pkg.sv =====
// Shared types and constants for the ARP resolver cache engine.
package arc_pkg;

  localparam int SLOT_W = 16;

  localparam logic [15:0] HWTYPE_ETH   = 16'h0001;
  localparam logic [15:0] PTYPE_IPV4   = 16'h0800;
  localparam logic [15:0] OP_REQUEST   = 16'h0001;
  localparam logic [15:0] OP_REPLY     = 16'h0002;
  localparam logic [7:0]  MAC_ADDR_LEN = 8'd6;
  localparam logic [7:0]  IPV4_LEN     = 8'd4;

  localparam logic [1:0] IN_RESOLVE = 2'd0;
  localparam logic [1:0] IN_PACKET  = 2'd1;
  localparam logic [1:0] IN_DISC    = 2'd2;

  localparam logic [1:0] RES_REQUEST = 2'd0;
  localparam logic [1:0] RES_REPLY   = 2'd1;
  localparam logic [1:0] RES_ANSWER  = 2'd2;
  localparam logic [1:0] RES_FAIL    = 2'd3;

  localparam logic [1:0] CFG_LOCAL_IP  = 2'd0;
  localparam logic [1:0] CFG_LOCAL_MAC = 2'd1;
  localparam logic [1:0] CFG_HW_TYPE   = 2'd2;
  localparam logic [1:0] CFG_IFINDEX   = 2'd3;

  typedef struct packed {
    logic [31:0]       ip;
    logic [47:0]       mac;
    logic [15:0]       ifx;
    logic              inc;
    logic [SLOT_W-1:0] waiters;
  } entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  client;
    logic [47:0] mac;
    logic [31:0] ip;
    logic [15:0] ifx;
    logic        last;
  } res_t;

endpackage

// ===== rtl/arc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module arc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/arc_oreg.sv =====
// Output register stage for result items.
module arc_oreg
  import arc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        emit_vld,
  input  res_t        emit,
  output logic        ok,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [3:0]  out_client,
  output logic [47:0] out_peer_mac,
  output logic [31:0] out_peer_ip,
  output logic [15:0] out_ifindex,
  output logic        out_last
);

  logic vld_r, vld_nxt;
  res_t res_r;

  assign ok = !vld_r || !out_stall;
  assign vld_nxt = emit_vld ? 1'b1 : (vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_vld) begin
      res_r <= emit;
    end
  end

  assign out_valid    = vld_r;
  assign out_kind     = res_r.kind;
  assign out_client   = res_r.client;
  assign out_peer_mac = res_r.mac;
  assign out_peer_ip  = res_r.ip;
  assign out_ifindex  = res_r.ifx;
  assign out_last     = res_r.last;

endmodule

// ===== rtl/arp_resolver_cache_engine_unit.sv =====
// Top level: ARP resolver with IPv4-to-MAC cache held in one RAM.
//
//  channel | ports                          | handshake
//  --------+--------------------------------+--------------------------
//  in      | in_kind .. in_rx_ifindex       | in_valid / in_stall
//  out     | out_kind .. out_last           | out_valid / out_stall
//  cfg     | cfg_idx, cfg_data              | cfg_we, no wait
//
// An item scans the filled part of the cache entry by entry (RAM read, compare), stopping
// at the first hit, then takes an action step and a drain step per answered waiter.
// A disconnect sweeps all filled entries. One item is in work at a time.
// Reset clears only the fill count and control; entries are allocated in order, never freed.
// Output stalls hold the sequencer in the action or drain step.
module arp_resolver_cache_engine_unit
  import arc_pkg::*;
#(
  parameter int CACHE_ENTRIES = 32,
  parameter int MAX_CLIENTS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [3:0]  in_client_id,
  input  logic [15:0] in_oper,
  input  logic [15:0] in_hw_type,
  input  logic [15:0] in_proto_type,
  input  logic [7:0]  in_hw_len,
  input  logic [7:0]  in_proto_len,
  input  logic [47:0] in_sender_mac,
  input  logic [31:0] in_sender_ip,
  input  logic [47:0] in_target_mac,
  input  logic [31:0] in_target_ip,
  input  logic [15:0] in_rx_ifindex,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [3:0]  out_client,
  output logic [47:0] out_peer_mac,
  output logic [31:0] out_peer_ip,
  output logic [15:0] out_ifindex,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [47:0] cfg_data
);

  localparam int IDXW = $clog2(CACHE_ENTRIES);
  localparam int CNTW = $clog2(CACHE_ENTRIES + 1);
  localparam logic [CNTW-1:0] FULL = CNTW'(CACHE_ENTRIES);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RD    = 5'b00010,
    S_CMP   = 5'b00100,
    S_ACT   = 5'b01000,
    S_DRAIN = 5'b10000
  } state_t;

  // configuration
  logic [31:0] lip_r;
  logic [47:0] lmac_r;
  logic [15:0] lhw_r;
  logic [15:0] lifx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lip_r  <= '0;
      lmac_r <= '0;
      lhw_r  <= HWTYPE_ETH;
      lifx_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_LOCAL_IP:  lip_r  <= cfg_data[31:0];
        CFG_LOCAL_MAC: lmac_r <= cfg_data;
        CFG_HW_TYPE:   lhw_r  <= cfg_data[15:0];
        CFG_IFINDEX:   lifx_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  state_t          state_r, state_nxt;
  logic [CNTW-1:0] fill_r, fill_nxt;
  logic [IDXW-1:0] idx_r, idx_nxt;
  logic            hit_r, hit_nxt;
  entry_t          ent_r, ent_nxt;
  logic [SLOT_W-1:0] wt_r, wt_nxt;

  // latched item
  logic [1:0]  kind_r;
  logic [3:0]  client_r;
  logic [47:0] smac_r;
  logic [31:0] sip_r, tip_r, key_r;
  logic [15:0] rifx_r;
  logic        req_r, local_r, bad_r;

  logic        ram_we;
  logic [IDXW-1:0] ram_waddr;
  entry_t      ram_wdata, ram_q;

  logic        emit_vld, out_ok;
  res_t        emit;

  logic        accept, req_ok, rep_ok, client_ok, full, last_idx;
  logic [SLOT_W-1:0] wbit, low_bit;
  logic [3:0]  low_idx;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = state_r != S_IDLE;
  assign client_ok = 32'(in_client_id) < MAX_CLIENTS;
  assign req_ok = in_oper == OP_REQUEST && in_hw_type == HWTYPE_ETH &&
                  in_hw_len == MAC_ADDR_LEN && in_proto_len == IPV4_LEN &&
                  in_proto_type == PTYPE_IPV4;
  assign rep_ok = in_oper == OP_REPLY && in_hw_type == lhw_r &&
                  in_proto_type == PTYPE_IPV4 && in_proto_len == IPV4_LEN &&
                  in_hw_len == MAC_ADDR_LEN && in_target_ip == lip_r &&
                  in_target_mac == lmac_r;
  assign full     = fill_r == FULL;
  assign last_idx = (CNTW'(idx_r) + CNTW'(1)) == fill_r;
  assign wbit     = SLOT_W'(1) << client_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r   <= in_kind;
      client_r <= in_client_id;
      smac_r   <= in_sender_mac;
      sip_r    <= in_sender_ip;
      tip_r    <= in_target_ip;
      rifx_r   <= in_rx_ifindex;
      key_r    <= (in_kind == IN_RESOLVE) ? in_target_ip : in_sender_ip;
      req_r    <= in_oper == OP_REQUEST;
      local_r  <= in_target_ip == lip_r;
      bad_r    <= !client_ok;
    end
  end

  // lowest waiting client
  always_comb begin
    low_idx = '0;
    for (int c = SLOT_W - 1; c >= 0; c--) begin
      if (wt_r[c]) begin
        low_idx = 4'(c);
      end
    end
    low_bit = SLOT_W'(1) << low_idx;
  end

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    idx_nxt   = idx_r;
    hit_nxt   = hit_r;
    ent_nxt   = ent_r;
    wt_nxt    = wt_r;
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = ram_q;
    emit_vld  = 1'b0;
    emit      = '0;
    case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        hit_nxt = 1'b0;
        if (accept) begin
          case (in_kind)
            IN_RESOLVE: begin
              if (!client_ok || fill_r == '0) state_nxt = S_ACT;
              else state_nxt = S_RD;
            end
            IN_PACKET: begin
              if (req_ok || rep_ok) state_nxt = (fill_r == '0) ? S_ACT : S_RD;
            end
            IN_DISC: begin
              if (client_ok && fill_r != '0) state_nxt = S_RD;
            end
            default: ;
          endcase
        end
      end
      S_RD: state_nxt = S_CMP;
      S_CMP: begin
        if (kind_r == IN_DISC) begin
          ram_we = 1'b1;
          ram_wdata.waiters = ram_q.waiters & ~wbit;
          if (last_idx) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + IDXW'(1);
            state_nxt = S_RD;
          end
        end else if (ram_q.ip == key_r) begin
          hit_nxt   = 1'b1;
          ent_nxt   = ram_q;
          state_nxt = S_ACT;
        end else if (last_idx) begin
          state_nxt = S_ACT;
        end else begin
          idx_nxt   = idx_r + IDXW'(1);
          state_nxt = S_RD;
        end
      end
      S_ACT: begin
        if (out_ok) begin
          state_nxt = S_IDLE;
          ram_wdata = ent_r;
          if (bad_r && kind_r == IN_RESOLVE) begin
            emit_vld = 1'b1;
            emit     = '{RES_FAIL, client_r, 48'd0, tip_r, 16'd0, 1'b1};
          end else if (kind_r == IN_RESOLVE) begin
            if (hit_r && ent_r.inc) begin
              ram_we = 1'b1;
              ram_wdata.waiters = ent_r.waiters | wbit;
            end else if (hit_r) begin
              emit_vld = 1'b1;
              emit     = '{RES_ANSWER, client_r, ent_r.mac, ent_r.ip, ent_r.ifx, 1'b1};
            end else if (full) begin
              emit_vld = 1'b1;
              emit     = '{RES_FAIL, client_r, 48'd0, tip_r, 16'd0, 1'b1};
            end else begin
              ram_we    = 1'b1;
              ram_waddr = fill_r[IDXW-1:0];
              ram_wdata = '{tip_r, 48'd0, 16'd0, 1'b1, wbit};
              fill_nxt  = fill_r + CNTW'(1);
              emit_vld  = 1'b1;
              emit      = '{RES_REQUEST, 4'd0, 48'd0, tip_r, lifx_r, 1'b1};
            end
          end else if (req_r && !local_r) begin
            if (hit_r && !ent_r.inc) begin
              ram_we = 1'b1;
              ram_wdata.mac = smac_r;
            end
          end else begin
            // local request or validated reply
            if (req_r) begin
              emit_vld = 1'b1;
              emit     = '{RES_REPLY, 4'd0, smac_r, sip_r, rifx_r,
                           !(hit_r && ent_r.inc && ent_r.waiters != '0)};
            end
            if (hit_r && (req_r || ent_r.inc)) begin
              ram_we = 1'b1;
              ram_wdata.mac = smac_r;
              ram_wdata.ifx = rifx_r;
              if (ent_r.inc) begin
                ram_wdata.inc     = 1'b0;
                ram_wdata.waiters = '0;
                ent_nxt.mac = smac_r;
                ent_nxt.ifx = rifx_r;
                wt_nxt      = ent_r.waiters;
                if (ent_r.waiters != '0) state_nxt = S_DRAIN;
              end
            end else if (!hit_r && req_r && !full) begin
              ram_we    = 1'b1;
              ram_waddr = fill_r[IDXW-1:0];
              ram_wdata = '{sip_r, smac_r, rifx_r, 1'b0, SLOT_W'(0)};
              fill_nxt  = fill_r + CNTW'(1);
            end
          end
        end
      end
      S_DRAIN: begin
        if (out_ok) begin
          emit_vld = 1'b1;
          emit     = '{RES_ANSWER, low_idx, ent_r.mac, ent_r.ip, ent_r.ifx,
                       (wt_r & ~low_bit) == '0};
          wt_nxt   = wt_r & ~low_bit;
          if ((wt_r & ~low_bit) == '0) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    hit_r <= hit_nxt;
    ent_r <= ent_nxt;
    wt_r  <= wt_nxt;
  end

  arc_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(CACHE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_q)
  );

  arc_oreg u_oreg (
    .clk          (clk),
    .rst_n        (rst_n),
    .emit_vld     (emit_vld),
    .emit         (emit),
    .ok           (out_ok),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_kind     (out_kind),
    .out_client   (out_client),
    .out_peer_mac (out_peer_mac),
    .out_peer_ip  (out_peer_ip),
    .out_ifindex  (out_ifindex),
    .out_last     (out_last)
  );

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL) else $error("fill count beyond cache size");

  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    emit_vld |-> out_ok) else $error("result emitted into occupied output register");

  a_write_addr: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> CNTW'(ram_waddr) <= fill_r) else $error("write beyond filled entries");

  a_alloc_full: assert property (@(posedge clk) disable iff (!rst_n)
    fill_nxt != fill_r |-> !full) else $error("allocation with full cache");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("output valid after reset");

endmodule
